/* src/latency_min_max_average_monitor_defines.svh */
// Assertion macros shared by the latency monitor checker.
`ifndef LATENCY_MIN_MAX_AVERAGE_MONITOR_DEFINES_SVH
`define LATENCY_MIN_MAX_AVERAGE_MONITOR_DEFINES_SVH

// Check a property on the rising clock, skipped while reset is high.
`define LMMAM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on the rising clock, reset included.
`define LMMAM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/lmmam_pkg.sv */
// Types and constants of the latency min/max/average monitor.
package lmmam_pkg;

   localparam int STAMP_BITS     = 32;
   localparam int SUM_BITS       = 42;
   localparam int ACC_BITS       = SUM_BITS + 1;
   localparam int WINDOW_BITS    = 11;
   localparam int SKIP_BITS      = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int MAX_WINDOW     = 1024;
   localparam int WINDOW_RESET   = 16;
   localparam int DIV_STEPS      = ACC_BITS;
   localparam int DIV_STEP_BITS  = $clog2(DIV_STEPS);

   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARMUP = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW = 1'd1;

   typedef struct packed {
      logic [STAMP_BITS-1:0] start_stamp;
      logic [STAMP_BITS-1:0] stop_stamp;
   } req_type;

   typedef struct packed {
      logic                  warming_up;
      logic [STAMP_BITS-1:0] busy_max;
      logic [STAMP_BITS-1:0] busy_min;
      logic [STAMP_BITS-1:0] busy_avg;
      logic [STAMP_BITS-1:0] gap_max;
      logic [STAMP_BITS-1:0] gap_min;
      logic [STAMP_BITS-1:0] gap_avg;
   } rsp_type;

   typedef struct packed {
      logic                  done;
      logic [STAMP_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

/* src/lmmam_serdiv.sv */
// Bit-serial restoring divider with a quotient saturated to the stamp width.
module lmmam_serdiv (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [lmmam_pkg::ACC_BITS-1:0]        dividend,
   input  logic [lmmam_pkg::WINDOW_BITS-1:0]     divisor,
   output lmmam_pkg::div_rsp_type                rsp
);

   localparam int AB = lmmam_pkg::ACC_BITS;
   localparam int WB = lmmam_pkg::WINDOW_BITS;
   localparam int SB = lmmam_pkg::STAMP_BITS;
   localparam int CB = lmmam_pkg::DIV_STEP_BITS;

   logic [AB-1:0] work_ff, work_in;
   logic [WB-1:0] rem_ff, rem_in;
   logic [WB-1:0] div_ff, div_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          active_ff, active_in;
   logic          done_ff, done_in;

   logic [WB:0]   trial;
   logic [WB:0]   diff;
   logic          fits;

   // One quotient bit per cycle: shift a dividend bit into the remainder
   assign trial = {rem_ff, work_ff[AB-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      work_in   = work_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         work_in   = dividend;
         rem_in    = '0;
         div_in    = divisor;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         work_in = {work_ff[AB-2:0], fits};
         rem_in  = fits ? diff[WB-1:0] : trial[WB-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CB'(lmmam_pkg::DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Hold control under reset, datapath free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // Saturate a quotient that overflows the stamp width
   assign rsp.done     = done_ff;
   assign rsp.quotient = (work_ff[AB-1:SB] != '0) ? lmmam_pkg::STAMP_MAX : work_ff[SB-1:0];

endmodule

/* src/latency_min_max_average_monitor.sv */
// Top level of the latency min/max/average monitor.
// Usage:
//  - req channel (valid/ready) takes one word with a task's start and stop stamps.
//  - rsp channel (valid/ready) returns one word per request: warm-up flag plus
//    max, min and leaky average of busy time (stop - start) and of the gap
//    between consecutive starts.
//  - csr port writes warmup_samples (index 0) and average_window (index 1)
//    while the block is idle; writes take effect at once.
// Flow: a warm-up word goes from accept to the hand-off state, then rsp_valid; a
//  counted word passes accumulate, trim, the 43-step bit-serial dividers (one per
//  average, running side by side) and hand-off before rsp_valid rises.
// Occupancy: one word at a time; req_ready returns in the same cycle that the
//  result moves to the output register.
// Reset: all statistics clear (minimums go to all ones), window returns to 16,
//  warm-up count to 0; no result is pending.
// Stall: the result register holds while rsp_ready is low; the next word is
//  still accepted and processed, and waits for the register to free up.
module latency_min_max_average_monitor (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  lmmam_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output lmmam_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_wr_en,
   input  logic [lmmam_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lmmam_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int SB = lmmam_pkg::STAMP_BITS;
   localparam int UB = lmmam_pkg::SUM_BITS;
   localparam int AB = lmmam_pkg::ACC_BITS;
   localparam int WB = lmmam_pkg::WINDOW_BITS;
   localparam int KB = lmmam_pkg::SKIP_BITS;
   localparam logic [WB-1:0] WIN_MAX = WB'(lmmam_pkg::MAX_WINDOW);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_TRIM,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [KB-1:0] warmup_ff;
   logic [WB-1:0] window_ff;

   // Statistics
   logic [KB-1:0] skipped_ff, skipped_in;
   logic [SB-1:0] prev_start_ff, prev_start_in;
   logic [SB-1:0] busy_max_ff, busy_max_in, busy_min_ff, busy_min_in;
   logic [SB-1:0] gap_max_ff, gap_max_in, gap_min_ff, gap_min_in;
   logic [UB-1:0] busy_sum_ff, busy_sum_in, gap_sum_ff, gap_sum_in;
   logic [SB-1:0] busy_avg_ff, busy_avg_in, gap_avg_ff, gap_avg_in;
   logic [WB-1:0] count_ff, count_in;

   // Per-word working registers
   logic [SB-1:0] busy_ff, busy_in, gap_ff, gap_in;
   logic          warm_ff, warm_in;
   logic          filling_ff, filling_in;
   logic [WB-1:0] divisor_ff, divisor_in;
   logic [AB-1:0] busy_acc_ff, busy_acc_in, gap_acc_ff, gap_acc_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   lmmam_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [WB-1:0] win_eff;
   logic          req_fire;
   logic [AB-1:0] busy_trim, gap_trim;
   logic          div_start;
   lmmam_pkg::div_rsp_type busy_div, gap_div;

   // Clamp the window into 1..MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WB'(1);
      end else if (window_ff > WIN_MAX) begin
         win_eff = WIN_MAX;
      end else begin
         win_eff = window_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;

   // Drop the old average off a full window, floor at zero
   always_comb begin
      busy_trim = busy_acc_ff;
      gap_trim  = gap_acc_ff;
      if (!filling_ff) begin
         busy_trim = (busy_acc_ff >= AB'(busy_avg_ff)) ? busy_acc_ff - AB'(busy_avg_ff) : '0;
         gap_trim  = (gap_acc_ff >= AB'(gap_avg_ff)) ? gap_acc_ff - AB'(gap_avg_ff) : '0;
      end
   end

   assign div_start = (state_ff == S_TRIM);

   lmmam_serdiv u_busy_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (busy_trim),
      .divisor  (divisor_ff),
      .rsp      (busy_div)
   );

   lmmam_serdiv u_gap_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (gap_trim),
      .divisor  (divisor_ff),
      .rsp      (gap_div)
   );

   // Sequence one word through accumulate, trim, divide and hand-off; a warm-up word goes straight to hand-off
   always_comb begin
      state_in      = state_ff;
      skipped_in    = skipped_ff;
      prev_start_in = prev_start_ff;
      busy_max_in   = busy_max_ff;
      busy_min_in   = busy_min_ff;
      gap_max_in    = gap_max_ff;
      gap_min_in    = gap_min_ff;
      busy_sum_in   = busy_sum_ff;
      gap_sum_in    = gap_sum_ff;
      busy_avg_in   = busy_avg_ff;
      gap_avg_in    = gap_avg_ff;
      count_in      = count_ff;
      busy_in       = busy_ff;
      gap_in        = gap_ff;
      warm_in       = warm_ff;
      filling_in    = filling_ff;
      divisor_in    = divisor_ff;
      busy_acc_in   = busy_acc_ff;
      gap_acc_in    = gap_acc_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               busy_in       = req_data.stop_stamp - req_data.start_stamp;
               gap_in        = req_data.start_stamp - prev_start_ff;
               prev_start_in = req_data.start_stamp;
               if (skipped_ff < warmup_ff) begin
                  skipped_in = skipped_ff + 1'b1;
                  warm_in    = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  warm_in    = 1'b0;
                  filling_in = count_ff < win_eff;
                  if (count_ff < win_eff) begin
                     count_in   = count_ff + 1'b1;
                     divisor_in = count_ff + 1'b1;
                  end else begin
                     divisor_in = win_eff;
                  end
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (busy_ff > busy_max_ff) busy_max_in = busy_ff;
            if (busy_ff < busy_min_ff) busy_min_in = busy_ff;
            if (gap_ff > gap_max_ff) gap_max_in = gap_ff;
            if (gap_ff < gap_min_ff) gap_min_in = gap_ff;
            busy_acc_in = AB'(busy_sum_ff) + AB'(busy_ff);
            gap_acc_in  = AB'(gap_sum_ff) + AB'(gap_ff);
            state_in    = S_TRIM;
         end
         S_TRIM: begin
            busy_sum_in = busy_trim[UB-1:0];
            gap_sum_in  = gap_trim[UB-1:0];
            state_in    = S_DIV;
         end
         S_DIV: begin
            if (busy_div.done && gap_div.done) begin
               busy_avg_in = busy_div.quotient;
               gap_avg_in  = gap_div.quotient;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.warming_up = warm_ff;
               rsp_data_in.busy_max   = busy_max_ff;
               rsp_data_in.busy_min   = busy_min_ff;
               rsp_data_in.busy_avg   = busy_avg_ff;
               rsp_data_in.gap_max    = gap_max_ff;
               rsp_data_in.gap_min    = gap_min_ff;
               rsp_data_in.gap_avg    = gap_avg_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, statistics and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         skipped_ff    <= '0;
         prev_start_ff <= '0;
         busy_max_ff   <= '0;
         busy_min_ff   <= lmmam_pkg::STAMP_MAX;
         gap_max_ff    <= '0;
         gap_min_ff    <= lmmam_pkg::STAMP_MAX;
         busy_sum_ff   <= '0;
         gap_sum_ff    <= '0;
         busy_avg_ff   <= '0;
         gap_avg_ff    <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         skipped_ff    <= skipped_in;
         prev_start_ff <= prev_start_in;
         busy_max_ff   <= busy_max_in;
         busy_min_ff   <= busy_min_in;
         gap_max_ff    <= gap_max_in;
         gap_min_ff    <= gap_min_in;
         busy_sum_ff   <= busy_sum_in;
         gap_sum_ff    <= gap_sum_in;
         busy_avg_ff   <= busy_avg_in;
         gap_avg_ff    <= gap_avg_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      busy_ff     <= busy_in;
      gap_ff      <= gap_in;
      warm_ff     <= warm_in;
      filling_ff  <= filling_in;
      divisor_ff  <= divisor_in;
      busy_acc_ff <= busy_acc_in;
      gap_acc_ff  <= gap_acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff <= '0;
         window_ff <= WB'(lmmam_pkg::WINDOW_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            lmmam_pkg::CSR_WARMUP: warmup_ff <= csr_wdata;
            lmmam_pkg::CSR_WINDOW: window_ff <= csr_wdata[WB-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/lmmam_checker.sv */
// Port-level assertions for the latency monitor, bound to the top level.
`include "latency_min_max_average_monitor_defines.svh"

module lmmam_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input lmmam_pkg::rsp_type rsp_data
);

   // Stalled result word holds
   `LMMAM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // One word in flight: ready drops right after an accept
   `LMMAM_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "second word accepted while busy")

   // Once counted, minimum never exceeds maximum
   `LMMAM_ASSERT(a_min_le_max, rsp_valid && !rsp_data.warming_up |-> rsp_data.busy_min <= rsp_data.busy_max && rsp_data.gap_min <= rsp_data.gap_max, "minimum above maximum")

   // No result pending right after reset
   `LMMAM_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind latency_min_max_average_monitor lmmam_checker u_lmmam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
